// ===== design/sfd_pkg.sv =====
package sfd_pkg;

   // payload widths
   localparam int DATA_W      = 16;
   localparam int IDX_W       = 5;
   localparam int FRAC_BITS   = 15;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 16;

   // request tdata field positions, lowest field first
   localparam int LEFT_LSB  = 0;
   localparam int RIGHT_LSB = LEFT_LSB + DATA_W;
   localparam int IDX_LSB   = RIGHT_LSB + DATA_W;
   localparam int COEF_LSB  = IDX_LSB + IDX_W;

   // request kind carried in tuser
   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_COEF   = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic acc_clear;
      logic issue;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic fir_due;
      logic tap_last;
      logic pipe_busy;
      logic out_free;
   } status_type;

endpackage

// ===== design/stereo_fir_decimator.sv =====
// channel  dir  tdata (lsb first)                               tuser
// req      in   left[15:0] right[31:16] coef_index[36:32]       action (1 = coef write)
//               coef_value[52:37], zero fill [55:53]
// rsp      out  mono_out[15:0]                                  -
//
// a coefficient write or a sample that completes no output is taken without a stall
// a sample that completes an output holds req_tready low while the single shared
// multiply-accumulate walks all TAPS taps, the pipeline drains and the output
// register is loaded
// synchronous active-high reset clears history and coefficients through valid bits
// a result still waiting holds the next filter output, and the input, until taken
module stereo_fir_decimator #(
   parameter int TAPS       = 32,
   parameter int DECIMATION = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sfd_pkg::REQ_TDATA_W-1:0] req_tdata,   // left, right, coef_index, coef_value
   input  logic                            req_tuser,   // action
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sfd_pkg::RSP_TDATA_W-1:0] rsp_tdata    // mono_out
);
   import sfd_pkg::*;

   cmd_type    cmd;
   status_type status;

   sfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sfd_datapath #(
      .TAPS       (TAPS),
      .DECIMATION (DECIMATION)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   // no transaction is taken while the mac pipeline still holds products
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !status.pipe_busy)
      else $error("input taken while mac pipeline busy");

   // a sample that completes an output stalls the input next cycle
   a_fir_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && status.fir_due) |=> !req_tready)
      else $error("input not stalled during filter run");

   // the output register is loaded only when its previous result is gone
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("pending result overwritten");

   // issue and output load never overlap
   a_issue_load: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !cmd.out_load)
      else $error("output loaded during tap walk");

endmodule

// ===== design/sfd_ctrl.sv =====
module sfd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  sfd_pkg::status_type status,
   output sfd_pkg::cmd_type    cmd
);
   import sfd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd.accept    = 1'b0;
      cmd.acc_clear = 1'b0;
      cmd.issue     = 1'b0;
      cmd.out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = accept;
            if (accept && status.fir_due) begin
               cmd.acc_clear = 1'b1;
               state_in      = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (status.tap_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/sfd_datapath.sv =====
module sfd_datapath #(
   parameter int TAPS       = 32,
   parameter int DECIMATION = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sfd_pkg::cmd_type                    cmd,
   output sfd_pkg::status_type                 status,
   input  logic [sfd_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [sfd_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);
   import sfd_pkg::*;

   localparam int PW    = $clog2(TAPS);
   localparam int PHW   = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
   localparam int ACC_W = 2 * DATA_W + $clog2(TAPS);
   localparam int SW    = ACC_W - FRAC_BITS;
   localparam logic signed [SW-1:0] SAT_MAX = SW'(32767);
   localparam logic signed [SW-1:0] SAT_MIN = SW'(-32768);

   // tap index wraps modulo the tap count, by repeated 8-bit subtraction of the tap count
   function automatic logic [PW-1:0] wrap_idx(input logic [IDX_W-1:0] v);
      logic [7:0] t;
      t = 8'(v);
      for (int k = 0; k < 8; k++) begin
         if (t >= 8'(TAPS)) begin
            t = t - 8'(TAPS);
         end
      end
      return PW'(t);
   endfunction

   // unpack the request
   logic                     action;
   logic signed [DATA_W-1:0] left, right, coef_value;
   logic [IDX_W-1:0]         coef_index;
   logic signed [DATA_W:0]   mix_sum;
   logic signed [DATA_W-1:0] mono;
   logic [PW-1:0]            coef_addr;

   assign action     = req_tuser;
   assign left       = req_tdata[LEFT_LSB +: DATA_W];
   assign right      = req_tdata[RIGHT_LSB +: DATA_W];
   assign coef_index = req_tdata[IDX_LSB +: IDX_W];
   assign coef_value = req_tdata[COEF_LSB +: DATA_W];
   assign mix_sum    = {left[DATA_W-1], left} + {right[DATA_W-1], right};
   assign mono       = mix_sum[DATA_W:1];
   assign coef_addr  = wrap_idx(coef_index);

   logic hist_we, coef_we;
   assign hist_we = cmd.accept & (action == ACTION_SAMPLE);
   assign coef_we = cmd.accept & (action == ACTION_COEF);

   // write pointer, decimation phase and tap counter
   logic [PW-1:0]  wp_ff, wp_in, tap_ff, tap_in;
   logic [PHW-1:0] phase_ff, phase_in;
   logic           phase_last;
   logic [PW:0]    hist_sum;
   logic [PW-1:0]  hist_addr;

   assign phase_last = (phase_ff == PHW'(DECIMATION - 1));
   assign wp_in      = (wp_ff == PW'(TAPS - 1)) ? '0 : wp_ff + PW'(1);
   assign phase_in   = phase_last ? '0 : phase_ff + PHW'(1);
   assign tap_in     = status.tap_last ? '0 : tap_ff + PW'(1);
   assign hist_sum   = {1'b0, wp_ff} + {1'b0, tap_ff};
   assign hist_addr  = (hist_sum >= (PW+1)'(TAPS)) ? PW'(hist_sum - (PW+1)'(TAPS))
                                                   : hist_sum[PW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         phase_ff <= '0;
         tap_ff   <= '0;
      end else begin
         if (hist_we) begin
            wp_ff    <= wp_in;
            phase_ff <= phase_in;
         end
         if (cmd.issue) begin
            tap_ff <= tap_in;
         end
      end
   end

   // history and coefficient memories, entries not yet written read as zero
   logic signed [DATA_W-1:0] hist_mem [TAPS];
   logic signed [DATA_W-1:0] coef_mem [TAPS];
   logic [TAPS-1:0]          hist_vld_ff, coef_vld_ff;
   logic signed [DATA_W-1:0] hist_rd_ff, coef_rd_ff;
   logic                     hist_ok_ff, coef_ok_ff;

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[wp_ff] <= mono;
      end
      if (coef_we) begin
         coef_mem[coef_addr] <= coef_value;
      end
      hist_rd_ff <= hist_mem[hist_addr];
      coef_rd_ff <= coef_mem[tap_ff];
      hist_ok_ff <= hist_vld_ff[hist_addr];
      coef_ok_ff <= coef_vld_ff[tap_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         coef_vld_ff <= '0;
      end else begin
         if (hist_we) begin
            hist_vld_ff[wp_ff] <= 1'b1;
         end
         if (coef_we) begin
            coef_vld_ff[coef_addr] <= 1'b1;
         end
      end
   end

   // multiply-accumulate pipeline: read, product, accumulate
   logic                       issue_d1_ff, issue_d2_ff;
   logic signed [DATA_W-1:0]   hist_eff, coef_eff;
   logic signed [2*DATA_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;

   assign hist_eff = hist_ok_ff ? hist_rd_ff : '0;
   assign coef_eff = coef_ok_ff ? coef_rd_ff : '0;
   assign prod_in  = coef_eff * hist_eff;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (issue_d2_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_d1_ff <= 1'b0;
         issue_d2_ff <= 1'b0;
      end else begin
         issue_d1_ff <= cmd.issue;
         issue_d2_ff <= issue_d1_ff;
      end
   end

   // scale down with floor and saturate to 16 bits
   logic signed [SW-1:0]     shifted;
   logic signed [DATA_W-1:0] sat;

   assign shifted = acc_ff[ACC_W-1:FRAC_BITS];

   always_comb begin
      if (shifted > SAT_MAX) begin
         sat = DATA_W'(SAT_MAX);
      end else if (shifted < SAT_MIN) begin
         sat = DATA_W'(SAT_MIN);
      end else begin
         sat = shifted[DATA_W-1:0];
      end
   end

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff;

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // status back to the controller
   assign status.fir_due   = (action == ACTION_SAMPLE) & phase_last;
   assign status.tap_last  = (tap_ff == PW'(TAPS - 1));
   assign status.pipe_busy = issue_d1_ff | issue_d2_ff;
   assign status.out_free  = ~rsp_valid_ff | rsp_tready;

endmodule
